/* rtl/core/pdga_pkg.sv */
// Shared types and constants for the Poisson disk grid acceptor.
// Grid geometry, field widths, command and result codes. No dependencies.
`timescale 1ns / 1ps

package pdga_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ADDR_W     = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;

	localparam int COORD_W    = 24;              // unsigned 16.8 coordinate
	localparam int IN_W       = COORD_W + 1;     // signed candidate coordinate
	localparam int SQ_W       = 2 * COORD_W;     // squared distance
	localparam int ENTRY_W    = 2 * COORD_W + 1; // {valid, x, y}
	localparam int DIM_W      = 7;
	localparam int COUNT_W    = 13;
	localparam int COUNT_CAP  = 4096;
	localparam int CFG_IDX_W  = 3;
	localparam int STATUS_W   = 3;
	localparam int OP_W       = 2;

	// 5x5 neighborhood around the candidate cell
	localparam int NBR_REACH  = 2;
	localparam int NBR_SPAN   = 2 * NBR_REACH + 1;
	localparam int NBR_W      = $clog2(NBR_SPAN);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 2'd0,
		OP_SEED    = 2'd1,
		OP_TRY     = 2'd2,
		OP_TRY_ALT = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPT  = 3'd0,
		ST_OOB     = 3'd1,
		ST_CLOSE   = 3'd2,
		ST_QUOTA   = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIELD_WIDTH  = 3'd0,
		CFG_FIELD_HEIGHT = 3'd1,
		CFG_MIN_DISTANCE = 3'd2,
		CFG_CELL_SIZE    = 3'd3,
		CFG_GRID_ROWS    = 3'd4,
		CFG_GRID_COLS    = 3'd5,
		CFG_POINT_QUOTA  = 3'd6
	} cfg_idx_t;

endpackage

/* rtl/core/pdga_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pdga_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/pdga_div.sv */
// Restoring divider, one quotient bit per cycle, for the cell index.
// Depends on pdga_pkg for the coordinate width.
`timescale 1ns / 1ps

module pdga_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pdga_pkg::COORD_W-1:0] dividend,
	input  logic [pdga_pkg::COORD_W-1:0] divisor,
	output logic                         done,
	output logic [pdga_pkg::COORD_W-1:0] quotient
);

	localparam int W     = pdga_pkg::COORD_W;
	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     div_q;
	logic [W:0]       trial;
	logic             fits;

	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? W'(trial - {1'b0, div_q}) : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/core/poisson_disk_grid_acceptor.sv */
// Top level of the Poisson disk grid acceptor: command sequencer, spacing scan
// over the grid memory, configuration registers. Uses pdga_pkg, pdga_div, pdga_ram.
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid/in_stall) carries one command per transaction:
// clear, seed or try a candidate at cand_x/cand_y. Output channel
// (out_valid/out_stall) returns one result per command: status, cell of the
// point and the placed count after the command. Configuration writes go over
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high. Write
// registers only while no command is in flight.
// A candidate that reaches the neighbor scan passes through the two cell-index
// dividers running side by side, memory reads over the 5x5 cells, the drain of
// the distance pipeline, the write-back and the output load. A seed skips the
// scan and drain; a point rejected at bounds or quota also skips the write-back.
// Clear sweeps all 4096 grid entries, one per cycle.
// One command is processed at a time; the next can be taken as soon as the
// result sits in the output register, even while the receiver stalls it.
// A held result stays stable until taken; a finished command waits for it.
// After reset the same sweep over all 4096 entries empties the grid with in_stall high.

module poisson_disk_grid_acceptor (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// command channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [pdga_pkg::OP_W-1:0]             opcode,
	input  logic signed [pdga_pkg::IN_W-1:0]      cand_x,
	input  logic signed [pdga_pkg::IN_W-1:0]      cand_y,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pdga_pkg::STATUS_W-1:0]         status,
	output logic [pdga_pkg::ROW_W-1:0]            cell_row,
	output logic [pdga_pkg::COL_W-1:0]            cell_col,
	output logic [pdga_pkg::COUNT_W-1:0]          placed_count,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pdga_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pdga_pkg::COORD_W-1:0]          cfg_data
);

	localparam int CW     = pdga_pkg::COORD_W;
	localparam int ROW_W  = pdga_pkg::ROW_W;
	localparam int COL_W  = pdga_pkg::COL_W;
	localparam int ADDR_W = pdga_pkg::ADDR_W;
	localparam int CNT_W  = pdga_pkg::COUNT_W;
	localparam int NBR_W  = pdga_pkg::NBR_W;
	localparam int SQ_W   = pdga_pkg::SQ_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_SCAN,
		S_DRAIN,
		S_COMMIT,
		S_DONE
	} state_t;

	// ---------------- configuration registers ----------------
	logic [CW-1:0]                  field_width_q;
	logic [CW-1:0]                  field_height_q;
	logic [CW-1:0]                  min_distance_q;
	logic [CW-1:0]                  cell_size_q;
	logic [pdga_pkg::DIM_W-1:0]     grid_rows_q;
	logic [pdga_pkg::DIM_W-1:0]     grid_cols_q;
	logic [CNT_W-1:0]               point_quota_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q  <= CW'(65536);
			field_height_q <= CW'(65536);
			min_distance_q <= CW'(2560);
			cell_size_q    <= CW'(1810);
			grid_rows_q    <= pdga_pkg::DIM_W'(37);
			grid_cols_q    <= pdga_pkg::DIM_W'(37);
			point_quota_q  <= CNT_W'(1000);
		end else if (cfg_valid && cfg_ready) begin
			unique case (pdga_pkg::cfg_idx_t'(cfg_index))
				pdga_pkg::CFG_FIELD_WIDTH:  field_width_q  <= cfg_data;
				pdga_pkg::CFG_FIELD_HEIGHT: field_height_q <= cfg_data;
				pdga_pkg::CFG_MIN_DISTANCE: min_distance_q <= cfg_data;
				pdga_pkg::CFG_CELL_SIZE:    cell_size_q    <= cfg_data;
				pdga_pkg::CFG_GRID_ROWS:    grid_rows_q    <= cfg_data[pdga_pkg::DIM_W-1:0];
				pdga_pkg::CFG_GRID_COLS:    grid_cols_q    <= cfg_data[pdga_pkg::DIM_W-1:0];
				pdga_pkg::CFG_POINT_QUOTA:  point_quota_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// grid extent in use, limited to the storage size
	logic [ROW_W:0] rows_lim;
	logic [COL_W:0] cols_lim;
	logic [CW-1:0]  cs_eff;

	always_comb begin
		rows_lim = (int'(grid_rows_q) < pdga_pkg::MAX_ROWS) ?
			(ROW_W+1)'(grid_rows_q) : (ROW_W+1)'(pdga_pkg::MAX_ROWS);
		cols_lim = (int'(grid_cols_q) < pdga_pkg::MAX_COLS) ?
			(COL_W+1)'(grid_cols_q) : (COL_W+1)'(pdga_pkg::MAX_COLS);
		cs_eff   = (cell_size_q == '0) ? CW'(1) : cell_size_q;
	end

	// ---------------- state ----------------
	state_t                      state_q;
	logic [ADDR_W-1:0]           clr_q;
	logic                        clr_cmd_q;
	pdga_pkg::op_t               op_q;
	logic [CW-1:0]               x_q;
	logic [CW-1:0]               y_q;
	logic                        inb0_q;
	logic [SQ_W-1:0]             lim_q;
	logic [ROW_W-1:0]            row_q;
	logic [COL_W-1:0]            col_q;
	pdga_pkg::status_t           status_q;
	logic [CNT_W-1:0]            placed_q;
	logic [NBR_W-1:0]            di_q;
	logic [NBR_W-1:0]            dj_q;
	logic                        out_valid_q;
	logic [pdga_pkg::STATUS_W-1:0] out_status_q;
	logic [ROW_W-1:0]            out_row_q;
	logic [COL_W-1:0]            out_col_q;
	logic [CNT_W-1:0]            out_count_q;

	logic in_acc;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// ---------------- cell index dividers ----------------
	logic          div_start;
	logic          div_r_done;
	logic          div_c_done;
	logic [CW-1:0] quot_r;
	logic [CW-1:0] quot_c;

	assign div_start = in_acc && (pdga_pkg::op_t'(opcode) != pdga_pkg::OP_CLEAR);

	pdga_div u_div_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cand_y[CW-1:0]),
		.divisor  (cs_eff),
		.done     (div_r_done),
		.quotient (quot_r)
	);

	pdga_div u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cand_x[CW-1:0]),
		.divisor  (cs_eff),
		.done     (div_c_done),
		.quotient (quot_c)
	);

	logic div_done;
	logic inb;
	logic quota_hit;

	always_comb begin
		div_done  = div_r_done && div_c_done;
		inb       = inb0_q && (quot_r < CW'(rows_lim)) && (quot_c < CW'(cols_lim));
		quota_hit = (placed_q >= point_quota_q) || (placed_q >= CNT_W'(pdga_pkg::COUNT_CAP));
	end

	// ---------------- neighbor address ----------------
	logic [ROW_W+1:0] nr_ext;
	logic [COL_W+1:0] nc_ext;
	logic [ROW_W-1:0] nr;
	logic [COL_W-1:0] nc;
	logic             nbr_ok;
	logic             scan_last;

	always_comb begin
		nr_ext = (ROW_W+2)'(row_q) + (ROW_W+2)'(di_q);
		nc_ext = (COL_W+2)'(col_q) + (COL_W+2)'(dj_q);
		nr     = ROW_W'(nr_ext - (ROW_W+2)'(pdga_pkg::NBR_REACH));
		nc     = COL_W'(nc_ext - (COL_W+2)'(pdga_pkg::NBR_REACH));
		nbr_ok = (nr_ext >= (ROW_W+2)'(pdga_pkg::NBR_REACH))
			&& (nc_ext >= (COL_W+2)'(pdga_pkg::NBR_REACH))
			&& ((nr_ext - (ROW_W+2)'(pdga_pkg::NBR_REACH)) < (ROW_W+2)'(rows_lim))
			&& ((nc_ext - (COL_W+2)'(pdga_pkg::NBR_REACH)) < (COL_W+2)'(cols_lim));
		scan_last = (di_q == NBR_W'(pdga_pkg::NBR_SPAN - 1))
			&& (dj_q == NBR_W'(pdga_pkg::NBR_SPAN - 1));
	end

	// ---------------- grid memory ----------------
	logic                         mem_we;
	logic [ADDR_W-1:0]            mem_waddr;
	logic [pdga_pkg::ENTRY_W-1:0] mem_wdata;
	logic                         mem_re;
	logic [ADDR_W-1:0]            mem_raddr;
	logic [pdga_pkg::ENTRY_W-1:0] mem_rdata;
	logic                         commit_acc;

	always_comb begin
		commit_acc = (state_q == S_COMMIT) && (status_q == pdga_pkg::ST_ACCEPT);
		mem_we     = (state_q == S_CLEAR) || commit_acc;
		mem_waddr  = (state_q == S_CLEAR) ? clr_q :
			ADDR_W'(ADDR_W'(row_q) * ADDR_W'(pdga_pkg::MAX_COLS) + ADDR_W'(col_q));
		mem_wdata  = (state_q == S_CLEAR) ? '0 : {1'b1, x_q, y_q};
		mem_re     = (state_q == S_SCAN) && nbr_ok;
		mem_raddr  = ADDR_W'(ADDR_W'(nr) * ADDR_W'(pdga_pkg::MAX_COLS) + ADDR_W'(nc));
	end

	pdga_ram #(
		.WIDTH (pdga_pkg::ENTRY_W),
		.DEPTH (pdga_pkg::GRID_DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// ---------------- distance pipeline ----------------
	logic            rd_v_s1;
	logic            v_s2;
	logic [CW-1:0]   dx_s2;
	logic [CW-1:0]   dy_s2;
	logic            v_s3;
	logic [SQ_W-1:0] sqx_s3;
	logic [SQ_W-1:0] sqy_s3;
	logic            close_q;
	logic [CW-1:0]   px;
	logic [CW-1:0]   py;
	logic            near_s3;
	logic            pipe_empty;

	always_comb begin
		px         = mem_rdata[2*CW-1:CW];
		py         = mem_rdata[CW-1:0];
		near_s3    = ({1'b0, sqx_s3} + {1'b0, sqy_s3}) < {1'b0, lim_q};
		pipe_empty = !rd_v_s1 && !v_s2 && !v_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			close_q <= 1'b0;
		end else begin
			rd_v_s1 <= mem_re;
			v_s2    <= rd_v_s1 && mem_rdata[pdga_pkg::ENTRY_W-1];
			v_s3    <= v_s2;
			if (in_acc) begin
				close_q <= 1'b0;
			end else if (v_s3 && near_s3) begin
				close_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= (px > x_q) ? (px - x_q) : (x_q - px);
		dy_s2  <= (py > y_q) ? (py - y_q) : (y_q - py);
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			clr_cmd_q    <= 1'b0;
			op_q         <= pdga_pkg::OP_CLEAR;
			x_q          <= '0;
			y_q          <= '0;
			inb0_q       <= 1'b0;
			lim_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			status_q     <= pdga_pkg::ST_ACCEPT;
			placed_q     <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			out_count_q  <= '0;
			di_q         <= '0;
			dj_q         <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					// the address wraps back to zero after the last entry
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(pdga_pkg::GRID_DEPTH - 1)) begin
						if (clr_cmd_q) begin
							placed_q <= '0;
							status_q <= pdga_pkg::ST_CLEARED;
							row_q    <= '0;
							col_q    <= '0;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						op_q   <= pdga_pkg::op_t'(opcode);
						x_q    <= cand_x[CW-1:0];
						y_q    <= cand_y[CW-1:0];
						inb0_q <= !cand_x[CW] && !cand_y[CW]
							&& (cand_x[CW-1:0] <= field_width_q)
							&& (cand_y[CW-1:0] <= field_height_q);
						lim_q  <= min_distance_q * min_distance_q;
						if (pdga_pkg::op_t'(opcode) == pdga_pkg::OP_CLEAR) begin
							clr_cmd_q <= 1'b1;
							clr_q     <= '0;
							state_q   <= S_CLEAR;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						di_q <= '0;
						dj_q <= '0;
						if (!inb) begin
							status_q <= pdga_pkg::ST_OOB;
							row_q    <= '0;
							col_q    <= '0;
							state_q  <= S_DONE;
						end else begin
							row_q <= quot_r[ROW_W-1:0];
							col_q <= quot_c[COL_W-1:0];
							if (op_q == pdga_pkg::OP_SEED) begin
								status_q <= pdga_pkg::ST_ACCEPT;
								state_q  <= S_COMMIT;
							end else if (quota_hit) begin
								status_q <= pdga_pkg::ST_QUOTA;
								state_q  <= S_DONE;
							end else begin
								status_q <= pdga_pkg::ST_ACCEPT;
								state_q  <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					// walk the 5x5 cells row by row, one per cycle; cells outside the grid are not read
					if (scan_last) begin
						state_q <= S_DRAIN;
					end else if (dj_q == NBR_W'(pdga_pkg::NBR_SPAN - 1)) begin
						dj_q <= '0;
						di_q <= di_q + 1'b1;
					end else begin
						dj_q <= dj_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (pipe_empty) begin
						if (close_q) begin
							status_q <= pdga_pkg::ST_CLOSE;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_COMMIT;
						end
					end
				end
				S_COMMIT: begin
					if (placed_q < CNT_W'(pdga_pkg::COUNT_CAP)) begin
						placed_q <= placed_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register frees up
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_row_q    <= row_q;
						out_col_q    <= col_q;
						out_count_q  <= placed_q;
						clr_cmd_q    <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign cell_row     = out_row_q;
	assign cell_col     = out_col_q;
	assign placed_count = out_count_q;

	// ---------------- assertions ----------------
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_DRAIN) |-> !mem_we)
		else $error("grid written during neighbor scan");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		placed_q <= CNT_W'(pdga_pkg::COUNT_CAP))
		else $error("placed count above cap");

	a_accept_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == pdga_pkg::ST_ACCEPT) |-> (placed_count != '0))
		else $error("accepted point with zero placed count");

	a_reject_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == pdga_pkg::ST_OOB || status == pdga_pkg::ST_CLEARED))
		|-> (cell_row == '0 && cell_col == '0))
		else $error("cell fields set on rejected or clear result");

	a_commit_bumps: assert property (@(posedge clk) disable iff (!arst_n)
		(commit_acc && placed_q < CNT_W'(pdga_pkg::COUNT_CAP))
		|=> (placed_q == $past(placed_q) + 1'b1))
		else $error("accepted point did not advance the count");

endmodule
